// File: rtl/core/rfpfd_pkg.sv
// Package: shared types, register indexes, status and command codes of the pulse frame decoder.
package rfpfd_pkg;

   localparam int PULSE_WIDTH_DEF = 12;
   localparam int THRESH_W        = 12;
   localparam int COUNT_W         = 8;
   localparam int ACC_W           = 32;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 12;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_MIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MID_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_MAX      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_PULSES    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PULSES    = 3'd4;

   localparam logic [THRESH_W-1:0] SHORT_MIN_RST     = 12'd26;
   localparam logic [THRESH_W-1:0] MID_THRESHOLD_RST = 12'd52;
   localparam logic [THRESH_W-1:0] LONG_MAX_RST      = 12'd74;
   localparam logic [COUNT_W-1:0]  MIN_PULSES_RST    = 8'd36;
   localparam logic [COUNT_W-1:0]  MAX_PULSES_RST    = 8'd52;

   // Frame status codes
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_BAD_COUNT    = 3'd1;
   localparam logic [2:0] ST_BAD_TIMING   = 3'd2;
   localparam logic [2:0] ST_EMPTY        = 3'd3;
   localparam logic [2:0] ST_BAD_PREAMBLE = 3'd4;
   localparam logic [2:0] ST_BAD_CHECK1   = 3'd5;
   localparam logic [2:0] ST_BAD_CHECK2   = 3'd6;

   // Commands
   localparam logic [2:0] CMD_OFF       = 3'd0;
   localparam logic [2:0] CMD_ON        = 3'd1;
   localparam logic [2:0] CMD_BRIGHTER  = 3'd2;
   localparam logic [2:0] CMD_DIMMER    = 3'd3;
   localparam logic [2:0] CMD_SET_LEVEL = 3'd4;

   // Switch codes with a fixed meaning
   localparam logic [5:0] SW_OFF      = 6'h16;
   localparam logic [5:0] SW_ON       = 6'h02;
   localparam logic [5:0] SW_BRIGHTER = 6'h00;
   localparam logic [5:0] SW_DIMMER   = 6'h04;

   localparam logic [3:0] PREAMBLE = 4'hE;
   localparam logic [1:0] CHECK_SEED = 2'h3;

   typedef struct packed {
      logic [THRESH_W-1:0] short_min;
      logic [THRESH_W-1:0] mid_threshold;
      logic [THRESH_W-1:0] long_max;
      logic [COUNT_W-1:0]  min_pulses;
      logic [COUNT_W-1:0]  max_pulses;
   } cfg_type;

   // One finished packet handed from the front to the back
   typedef struct packed {
      logic [ACC_W-1:0]   acc;
      logic [COUNT_W-1:0] count;
      logic               timing_err;
   } frame_type;

   typedef struct packed {
      logic [3:0]  level;
      logic [2:0]  command;
      logic [5:0]  switch_code;
      logic [13:0] unit_id;
      logic [2:0]  status;
   } result_type;

endpackage

// File: rtl/core/rfpfd_front.sv
// Front end: classify pulses, assemble bits and hand each finished packet to the queue.
module rfpfd_front #(
   parameter int PULSE_WIDTH = rfpfd_pkg::PULSE_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [PULSE_WIDTH-1:0]    req_pulse_len,
   input  logic                      req_last,
   input  rfpfd_pkg::cfg_type        cfg,
   input  logic                      push_ready,
   output logic                      push_valid,
   output rfpfd_pkg::frame_type      push_frame
);

   localparam int CmpW = (PULSE_WIDTH > rfpfd_pkg::THRESH_W) ? PULSE_WIDTH
                                                             : rfpfd_pkg::THRESH_W;

   logic [rfpfd_pkg::ACC_W-1:0]   acc_ff, acc_in, step_acc;
   logic [rfpfd_pkg::COUNT_W-1:0] cnt_ff, cnt_in, step_cnt;
   logic                          half_ff, half_in, step_half;
   logic                          terr_ff, terr_in, step_terr;
   logic                          accept;
   logic [CmpW-1:0]               p_ext, smin_ext, mid_ext, lmax_ext;
   logic                          is_long, too_long, too_short;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;

   assign p_ext     = CmpW'(req_pulse_len);
   assign smin_ext  = CmpW'(cfg.short_min);
   assign mid_ext   = CmpW'(cfg.mid_threshold);
   assign lmax_ext  = CmpW'(cfg.long_max);
   assign is_long   = p_ext > mid_ext;
   assign too_long  = p_ext > lmax_ext;
   assign too_short = p_ext < smin_ext;

   always_comb begin
      step_acc  = acc_ff;
      step_cnt  = cnt_ff;
      step_half = half_ff;
      step_terr = terr_ff;
      if (cnt_ff != rfpfd_pkg::COUNT_MAX) begin
         step_cnt = cnt_ff + 1'b1;
      end
      if (!terr_ff) begin
         if (half_ff) begin
            // second half of a short pair
            step_half = 1'b0;
            if (is_long || too_short) begin
               step_terr = 1'b1;
            end else begin
               step_acc = {acc_ff[rfpfd_pkg::ACC_W-2:0], 1'b1};
            end
         end else if (!req_last) begin
            if (is_long) begin
               if (too_long) begin
                  step_terr = 1'b1;
               end else begin
                  step_acc = {acc_ff[rfpfd_pkg::ACC_W-2:0], 1'b0};
               end
            end else if (too_short) begin
               step_terr = 1'b1;
            end else begin
               step_half = 1'b1;
            end
         end
      end
   end

   always_comb begin
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      half_in = half_ff;
      terr_in = terr_ff;
      if (accept) begin
         if (req_last) begin
            acc_in  = '0;
            cnt_in  = '0;
            half_in = 1'b0;
            terr_in = 1'b0;
         end else begin
            acc_in  = step_acc;
            cnt_in  = step_cnt;
            half_in = step_half;
            terr_in = step_terr;
         end
      end
   end

   assign push_valid            = accept && req_last;
   assign push_frame.acc        = step_acc;
   assign push_frame.count      = step_cnt;
   assign push_frame.timing_err = step_terr;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         cnt_ff  <= '0;
         half_ff <= 1'b0;
         terr_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         half_ff <= half_in;
         terr_ff <= terr_in;
      end
   end

endmodule

// File: rtl/core/rfpfd_queue.sv
// Short frame queue between the front and the back.
module rfpfd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  rfpfd_pkg::frame_type  push_frame,
   output logic                  pop_valid,
   input  logic                  pop,
   output rfpfd_pkg::frame_type  pop_frame
);

   localparam int PtrW = $clog2(rfpfd_pkg::QUEUE_DEPTH);
   localparam int CntW = $clog2(rfpfd_pkg::QUEUE_DEPTH + 1);

   rfpfd_pkg::frame_type entry_ff [rfpfd_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic            do_push, do_pop;

   assign push_ready = fill_ff != CntW'(rfpfd_pkg::QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_frame  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// File: rtl/core/rfpfd_back.sv
// Back end: check a finished packet, decode its fields and hold the result for transfer.
module rfpfd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  rfpfd_pkg::frame_type   head_frame,
   output logic                   pop,
   input  logic [rfpfd_pkg::COUNT_W-1:0] min_pulses,
   input  logic [rfpfd_pkg::COUNT_W-1:0] max_pulses,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output rfpfd_pkg::result_type  rsp_result
);

   logic                  rsp_valid_ff, rsp_valid_in;
   rfpfd_pkg::result_type rsp_ff, rsp_in;
   logic [31:0]           b;
   logic [13:0]           uid;
   logic [5:0]            sw;
   logic [1:0]            ck1, ck2;
   logic [2:0]            status;

   assign b   = head_frame.acc;
   assign uid = b[23:10];
   assign sw  = b[7:2];

   always_comb begin
      ck1 = rfpfd_pkg::CHECK_SEED;
      for (int i = 0; i < 7; i++) begin
         ck1 = ck1 ^ uid[2*i +: 2];
      end
      ck2 = rfpfd_pkg::CHECK_SEED;
      for (int i = 0; i < 3; i++) begin
         ck2 = ck2 ^ sw[2*i +: 2];
      end
   end

   always_comb begin
      if (head_frame.count < min_pulses || head_frame.count > max_pulses) begin
         status = rfpfd_pkg::ST_BAD_COUNT;
      end else if (head_frame.timing_err) begin
         status = rfpfd_pkg::ST_BAD_TIMING;
      end else if (b == '0) begin
         status = rfpfd_pkg::ST_EMPTY;
      end else if (b[27:24] != rfpfd_pkg::PREAMBLE) begin
         status = rfpfd_pkg::ST_BAD_PREAMBLE;
      end else if (b[9:8] != ck1) begin
         status = rfpfd_pkg::ST_BAD_CHECK1;
      end else if (b[1:0] != ck2) begin
         status = rfpfd_pkg::ST_BAD_CHECK2;
      end else begin
         status = rfpfd_pkg::ST_OK;
      end
   end

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = status;
      if (status == rfpfd_pkg::ST_OK) begin
         rsp_in.unit_id     = uid;
         rsp_in.switch_code = sw;
         case (sw)
            rfpfd_pkg::SW_ON:       rsp_in.command = rfpfd_pkg::CMD_ON;
            rfpfd_pkg::SW_OFF:      rsp_in.command = rfpfd_pkg::CMD_OFF;
            rfpfd_pkg::SW_BRIGHTER: rsp_in.command = rfpfd_pkg::CMD_BRIGHTER;
            rfpfd_pkg::SW_DIMMER:   rsp_in.command = rfpfd_pkg::CMD_DIMMER;
            default: begin
               rsp_in.command = rfpfd_pkg::CMD_SET_LEVEL;
               rsp_in.level   = {sw[2], sw[3], sw[4], sw[5]};
            end
         endcase
      end
   end

   // take the next packet whenever the output register is free or drains now
   assign pop          = head_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

// File: rtl/core/rf_remote_pulse_frame_decoder.sv
// Top level: RF remote pulse frame decoder with configuration registers.
//
//  Channel  Dir  Handshake              Payload
//  req      in   req_tvalid/req_tready  tdata: pulse_len; tlast: last pulse of packet
//  rsp      out  rsp_tvalid/rsp_tready  tdata: status, unit_id, switch_code, command, level
//  csr      in   csr_we                 csr_index selects register, csr_wdata value
//
// One pulse is taken per cycle. The front updates the packet state in the cycle of the
// transfer; a last pulse pushes the finished packet into a four-entry queue. The back
// checks and decodes one packet per cycle into the output register while the output is
// not stalled; a packet passes a queue entry, then the output register. Reset clears the
// packet state, the queue and the output valid, and loads the register defaults. The
// input stalls only while the queue is full; a stalled output holds its result.
module rf_remote_pulse_frame_decoder #(
   parameter int PULSE_WIDTH = rfpfd_pkg::PULSE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pulse_len in the low PULSE_WIDTH bits, zeros above
   input  logic [((PULSE_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[2:0], unit_id[16:3], switch_code[22:17], command[25:23], level[29:26], zeros
   output logic [31:0]                         rsp_tdata,
   input  logic                                csr_we,
   input  logic [rfpfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rfpfd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   rfpfd_pkg::cfg_type    cfg_ff, cfg_in;
   rfpfd_pkg::frame_type  push_frame, head_frame;
   rfpfd_pkg::result_type rsp_result;
   logic                  push_valid, push_ready, head_valid, pop;

   // Register writes: keep the low bits that each register holds
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rfpfd_pkg::REG_SHORT_MIN:     cfg_in.short_min     = csr_wdata;
            rfpfd_pkg::REG_MID_THRESHOLD: cfg_in.mid_threshold = csr_wdata;
            rfpfd_pkg::REG_LONG_MAX:      cfg_in.long_max      = csr_wdata;
            rfpfd_pkg::REG_MIN_PULSES:
               cfg_in.min_pulses = csr_wdata[rfpfd_pkg::COUNT_W-1:0];
            rfpfd_pkg::REG_MAX_PULSES:
               cfg_in.max_pulses = csr_wdata[rfpfd_pkg::COUNT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_min     <= rfpfd_pkg::SHORT_MIN_RST;
         cfg_ff.mid_threshold <= rfpfd_pkg::MID_THRESHOLD_RST;
         cfg_ff.long_max      <= rfpfd_pkg::LONG_MAX_RST;
         cfg_ff.min_pulses    <= rfpfd_pkg::MIN_PULSES_RST;
         cfg_ff.max_pulses    <= rfpfd_pkg::MAX_PULSES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: classify each pulse and assemble the packet
   rfpfd_front #(
      .PULSE_WIDTH(PULSE_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_pulse_len (req_tdata[PULSE_WIDTH-1:0]),
      .req_last      (req_tlast),
      .cfg           (cfg_ff),
      .push_ready    (push_ready),
      .push_valid    (push_valid),
      .push_frame    (push_frame)
   );

   // Queue: decouple packet assembly from checking and output stalls
   rfpfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame),
      .pop_valid  (head_valid),
      .pop        (pop),
      .pop_frame  (head_frame)
   );

   // Back: check, decode and hold the result for transfer
   rfpfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_frame (head_frame),
      .pop        (pop),
      .min_pulses (cfg_ff.min_pulses),
      .max_pulses (cfg_ff.max_pulses),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {2'b00, rsp_result};

endmodule
